// ===== rtl/aes128_ctr_stream_cipher_macros.svh =====
// assertion macros for the aes-128 ctr stream cipher
// included by the modules that carry assertions
`ifndef AES128_CTR_STREAM_CIPHER_MACROS_SVH
`define AES128_CTR_STREAM_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
`define ACS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ACS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACS_ASSERT(label, clk, rst, prop, msg)
`define ACS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/acs_pkg.sv =====
// shared types, constants and aes functions for the ctr stream cipher
// no dependencies
`timescale 1ns / 1ps
package acs_pkg;
   localparam int NumRounds = 10;
   localparam int QueueDepth = 2;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       first;
   } item_type;

   typedef enum logic [1:0] {
      REG_KEY_HIGH = 2'd0,
      REG_KEY_LOW  = 2'd1,
      REG_IV_HIGH  = 2'd2,
      REG_IV_LOW   = 2'd3
   } reg_index_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits 127-8i .. 120-8i
   function automatic logic [7:0] blk_byte(input block_type b, input int i);
      return b[127 - 8 * i -: 8];
   endfunction

   function automatic block_type next_round_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic block_type aes_round(input block_type s, input block_type rk,
                                           input logic do_mix);
      block_type t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[127 - 8 * (i + 4 * c) -: 8] = sbox(blk_byte(s, i + 4 * ((c + i) % 4)));
         end
      end
      if (do_mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = blk_byte(t, 4 * c);
            a1 = blk_byte(t, 4 * c + 1);
            a2 = blk_byte(t, 4 * c + 2);
            a3 = blk_byte(t, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8]      = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8]      = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8]      = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8]      = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      return t ^ rk;
   endfunction
endpackage

// ===== rtl/aes128_ctr_stream_cipher.sv =====
// aes-128 counter mode byte stream cipher, top level with apb registers
// depends on acs_pkg, acs_front, acs_back
// A byte that opens a keystream block (the first of a message and every 16th
// after it) waits in the back end for the AES rounds, done one per cycle on a
// single round unit with on-the-fly key expansion; other bytes are xored with the
// held keystream. A two-entry queue in front keeps accepting during the rounds until full.
// Registers: 0 key_high, 1 key_low, 2 iv_high, 3 iv_low, 64 bits at 8*i.
`timescale 1ns / 1ps
module aes128_ctr_stream_cipher import acs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   logic [63:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic        q_valid, q_ready, wr;
   item_type    q_item;
   logic [1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
      end else if (wr && csr_paddr[2:0] == 3'd0) begin
         case (reg_index_type'(idx))
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            REG_IV_HIGH:  iv_high_ff  <= csr_pwdata;
            REG_IV_LOW:   iv_low_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(idx))
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_IV_HIGH:  csr_prdata = iv_high_ff;
         REG_IV_LOW:   csr_prdata = iv_low_ff;
         default:      csr_prdata = '0;
      endcase
   end

   acs_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .in_last(req_tlast),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   acs_back u_back (
      .clock(clock), .reset(reset),
      .key_high(key_high_ff), .key_low(key_low_ff),
      .iv_high(iv_high_ff), .iv_low(iv_low_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );
endmodule

// ===== rtl/acs_front.sv =====
// front end: accepts bytes, marks block starts, holds them in a short queue
// depends on acs_pkg
`timescale 1ns / 1ps
`include "aes128_ctr_stream_cipher_macros.svh"
module acs_front import acs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_data,
   input  logic       in_last,
   output logic       q_valid,
   input  logic       q_ready,
   output item_type   q_item
);
   item_type   mem_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [3:0] pos_ff, pos_in;
   logic       push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = mem_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      pos_in    = pos_ff;
      if (push) begin
         pos_in = in_last ? 4'd0 : pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         pos_ff    <= 4'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{data: in_data, last: in_last, first: (pos_ff == 4'd0)};
      end
   end

   `ACS_ASSERT(a_count_range, clock, reset, count_ff != 2'd3, "queue count out of range")
   `ACS_ASSERT(a_no_overflow, clock, reset, (count_ff == 2'd2) |-> !in_ready, "queue overflow")
   `ACS_ASSERT(a_ptr_match, clock, reset,
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff), "queue pointers off")
endmodule

// ===== rtl/acs_back.sv =====
// back end: runs aes-128 one round a cycle on the counter, xors bytes
// depends on acs_pkg
`timescale 1ns / 1ps
`include "aes128_ctr_stream_cipher_macros.svh"
module acs_back import acs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] key_high,
   input  logic [63:0] key_low,
   input  logic [63:0] iv_high,
   input  logic [63:0] iv_low,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_data
);
   typedef enum logic [1:0] {S_IDLE, S_ROUND, S_EMIT} state_type;

   state_type  state_ff;
   block_type  ctr_ff, state_blk_ff, rkey_ff, ks_ff;
   logic [3:0] round_ff, pos_ff;
   logic       msg_start_ff;
   logic [7:0] rcon_ff;
   logic       out_valid_ff;
   logic [7:0] out_data_ff;
   block_type  cur_ctr, rk_next;
   logic       set_out;

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign q_ready   = (state_ff == S_IDLE) && (!out_valid_ff || out_ready);
   assign cur_ctr   = msg_start_ff ? {iv_high, iv_low} : ctr_ff;
   assign rk_next   = next_round_key(rkey_ff, rcon_ff);
   // a result is shown after the keystream is ready or for a mid-block byte
   assign set_out   = (state_ff == S_EMIT) ||
                      ((state_ff == S_IDLE) && q_valid && q_ready && !q_item.first);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         msg_start_ff <= 1'b1;
         ctr_ff       <= '0;
         ks_ff        <= '0;
         pos_ff       <= 4'd0;
         round_ff     <= 4'd0;
         rcon_ff      <= 8'h01;
      end else begin
         if (set_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid && q_ready) begin
                  if (q_item.first) begin
                     state_blk_ff <= cur_ctr ^ {key_high, key_low};
                     rkey_ff      <= {key_high, key_low};
                     rcon_ff      <= 8'h01;
                     round_ff     <= 4'd1;
                     ctr_ff       <= cur_ctr + 128'd1;
                     pos_ff       <= 4'd0;
                     out_data_ff  <= q_item.data;
                     msg_start_ff <= q_item.last;
                     state_ff     <= S_ROUND;
                  end else begin
                     out_data_ff  <= q_item.data ^ blk_byte(ks_ff, int'(pos_ff));
                     pos_ff       <= pos_ff + 4'd1;
                     msg_start_ff <= q_item.last;
                  end
               end
            end
            S_ROUND: begin
               state_blk_ff <= aes_round(state_blk_ff, rk_next, round_ff != 4'(NumRounds));
               rkey_ff      <= rk_next;
               rcon_ff      <= xtime(rcon_ff);
               round_ff     <= round_ff + 4'd1;
               if (round_ff == 4'(NumRounds)) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               ks_ff        <= state_blk_ff;
               out_data_ff  <= out_data_ff ^ state_blk_ff[127:120];
               pos_ff       <= 4'd1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ACS_ASSERT(a_round_range, clock, reset,
      (state_ff == S_ROUND) |-> (round_ff >= 4'd1 && round_ff <= 4'(NumRounds)), "bad round")
   `ACS_ASSERT(a_emit_done, clock, reset, (state_ff == S_EMIT) |=> out_valid_ff,
      "keystream byte not shown")
   `ACS_ASSERT(a_hold_out, clock, reset, (out_valid_ff && !out_ready) |=> out_valid_ff,
      "result dropped")
endmodule

// ===== tb/aes128_ctr_stream_cipher_checker.sv =====
// checker for the aes-128 ctr stream cipher: predicts each output byte and compares
// depends on acs_pkg for reg_index_type only
`timescale 1ns / 1ps
module aes128_ctr_stream_cipher_checker import acs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_count,
   output int          block_count
);
   logic [7:0] sub_box [256];
   logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
   logic [127:0] ctr_value;
   logic [7:0] stream_bytes [16];
   logic [3:0] stream_pos;
   logic msg_open;
   logic [7:0] cipher_bytes_q [$];

   function automatic logic [7:0] gmul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] inv_of(input logic [7:0] a);
      logic [7:0] r, p, x;
      r = 8'h01;
      for (int n = 0; n < 254; n++) begin
         p = 8'h00; x = r;
         for (int b = 0; b < 8; b++) begin
            if (a[b]) p = p ^ x;
            x = gmul2(x);
         end
         r = p;
      end
      return r;
   endfunction

   initial begin
      logic [7:0] v, s;
      for (int i = 0; i < 256; i++) begin
         v = (i == 0) ? 8'h00 : inv_of(i[7:0]);
         s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
             ^ 8'h63;
         sub_box[i] = s;
      end
   end

   task automatic fill_keystream(input logic [127:0] blk);
      logic [7:0] rk [176];
      logic [7:0] st [16];
      logic [7:0] tt [16];
      logic [7:0] tw [4];
      logic [7:0] x, rc, a0, a1, a2, a3, al;
      for (int i = 0; i < 8; i++) begin
         rk[i] = key_hi[63 - 8 * i -: 8];
         rk[8 + i] = key_lo[63 - 8 * i -: 8];
      end
      rc = 8'h01;
      for (int w = 4; w < 44; w++) begin
         for (int j = 0; j < 4; j++) tw[j] = rk[4 * (w - 1) + j];
         if (w % 4 == 0) begin
            x = tw[0];
            tw[0] = sub_box[tw[1]] ^ rc;
            tw[1] = sub_box[tw[2]];
            tw[2] = sub_box[tw[3]];
            tw[3] = sub_box[x];
            rc = gmul2(rc);
         end
         for (int j = 0; j < 4; j++) rk[4 * w + j] = rk[4 * (w - 4) + j] ^ tw[j];
      end
      for (int i = 0; i < 16; i++) st[i] = blk[127 - 8 * i -: 8] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) tt[i + 4 * c] = sub_box[st[i + 4 * ((c + i) % 4)]];
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = tt[4 * c]; a1 = tt[4 * c + 1]; a2 = tt[4 * c + 2]; a3 = tt[4 * c + 3];
               al = a0 ^ a1 ^ a2 ^ a3;
               tt[4 * c] = a0 ^ al ^ gmul2(a0 ^ a1);
               tt[4 * c + 1] = a1 ^ al ^ gmul2(a1 ^ a2);
               tt[4 * c + 2] = a2 ^ al ^ gmul2(a2 ^ a3);
               tt[4 * c + 3] = a3 ^ al ^ gmul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = tt[i] ^ rk[16 * r + i];
      end
      for (int i = 0; i < 16; i++) stream_bytes[i] = st[i];
   endtask

   assign pending_count = cipher_bytes_q.size();

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         key_hi <= '0; key_lo <= '0; iv_hi <= '0; iv_lo <= '0;
         ctr_value = '0;
         stream_pos = '0;
         msg_open = 1'b0;
         for (int i = 0; i < 16; i++) stream_bytes[i] = 8'h00;
         cipher_bytes_q.delete();
         mismatch_count <= 0;
         block_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:3]))
               REG_KEY_HIGH: key_hi <= csr_pwdata;
               REG_KEY_LOW:  key_lo <= csr_pwdata;
               REG_IV_HIGH:  iv_hi <= csr_pwdata;
               REG_IV_LOW:   iv_lo <= csr_pwdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (!msg_open) begin
               ctr_value = {iv_hi, iv_lo};
               stream_pos = '0;
               msg_open = 1'b1;
            end
            if (stream_pos == 4'h0) begin
               fill_keystream(ctr_value);
               ctr_value = ctr_value + 128'd1;
               block_count <= block_count + 1;
            end
            cipher_bytes_q.push_back(req_tdata ^ stream_bytes[stream_pos]);
            stream_pos = stream_pos + 4'h1;
            if (req_tlast) msg_open = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_bytes_q.size() == 0) begin
               $display("%0t: unexpected output byte, expected none, actual %02h",
                        $time, rsp_tdata);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = cipher_bytes_q.pop_front();
               if (want !== rsp_tdata) begin
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want, rsp_tdata);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/tb_aes128_ctr_stream_cipher.sv =====
// testbench top for the aes-128 ctr stream cipher: clock, reset, stimulus, verdict
// depends on acs_pkg, the cipher rtl and aes128_ctr_stream_cipher_checker
`timescale 1ns / 1ps
module tb_aes128_ctr_stream_cipher import acs_pkg::*; ();

   localparam int WatchLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   int mismatch_count, pending_count, block_count;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int byte_total = 0, quiet_cycles = 0;

   always #5 clock = ~clock;

   aes128_ctr_stream_cipher i_dut (.*);

   aes128_ctr_stream_cipher_checker i_checker (.*);

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WatchLimit) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [63:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic end_mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1; req_tdata <= value; req_tlast <= end_mark;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      byte_total++;
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_setting(input logic [63:0] kh, input logic [63:0] kl,
                               input logic [63:0] ih, input logic [63:0] il);
      drain_all();
      write_reg(REG_KEY_HIGH, kh);
      write_reg(REG_KEY_LOW, kl);
      write_reg(REG_IV_HIGH, ih);
      write_reg(REG_IV_LOW, il);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(255)), i == len - 1);
   endtask

   task automatic random_phase(input int budget);
      int goal, len;
      goal = byte_total + budget;
      while (byte_total < goal) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 20);
         send_message(len);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: reset key, extreme bytes, block boundary, counter wrap
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'haa, 1'b1);
      load_setting('1, '1, '1, 64'hffff_ffff_ffff_fffe);
      send_message(20);
      send_message(1);
      load_setting(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                   64'h0123456789abcdef, '1);
      send_message(18);
      // write mid-message: key applies at next block, iv at next message
      send_byte(8'h11, 1'b0);
      drain_all();
      write_reg(REG_KEY_LOW, 64'h0f0e0d0c0b0a0908);
      write_reg(REG_IV_HIGH, 64'h8000_0000_0000_0000);
      for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), i == 19);
      send_idle_pct = 26; recv_idle_pct = 48;
      random_phase(230);
      load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   64'hffff_ffff_ffff_fff0);
      send_idle_pct = 48; recv_idle_pct = 26;
      random_phase(230);
      load_setting('0, '1, {$urandom, $urandom}, '0);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(230);
      drain_all();
      $display("%0d bytes sent in %0d keystream blocks under five key and iv settings",
               byte_total, block_count);
      $display("with idle sender, idle receiver and full rate phases");
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
